@@ hw/rtl/tsd_pkg.sv @@
// Shared types, constants and the tanh breakpoint table of the soft-clip core.
package tsd_pkg;

  localparam int unsigned SampleW      = 16;
  localparam int unsigned GainW        = 16;
  localparam int unsigned MixW         = 13;
  localparam int unsigned MixOne       = 4096;
  localparam int unsigned TanhSegments = 64;
  localparam int unsigned SegW         = $clog2(TanhSegments);
  localparam int unsigned MagW         = 2 * SampleW;
  // |d| in Q5.27; 4.0 sits at bit 29
  localparam int unsigned FourBit      = 29;
  localparam int unsigned FracW        = FourBit - SegW;
  localparam int unsigned ShapedW      = SampleW + 1;
  localparam int unsigned BlendW       = 29;
  localparam int unsigned ScaledW      = BlendW + GainW + 1;
  localparam int unsigned RoundShift   = 24;

  localparam logic [63:0] OneQ32  = 64'h1_0000_0000;
  localparam logic [63:0] ExpM1Q32 = 64'd1580030169;

  typedef enum logic [1:0] {
    CFG_DRIVE_GAIN = 2'd0,
    CFG_WET_MIX    = 2'd1,
    CFG_POST_GAIN  = 2'd2
  } cfg_idx_e;

  typedef logic [SampleW-1:0] shape_tab_t [TanhSegments+1];

  // Word handed from the shaper to the mixer.
  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [ShapedW-1:0] w;
  } shaped_t;

  // Unsigned 64-bit quotient by restoring shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    int          b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8k/S) in Q32, evaluated at elaboration only
  function automatic logic [63:0] exp_neg_q32(int unsigned k);
    logic [63:0]    a;
    logic [63:0]    whole;
    logic [63:0]    frac;
    logic [63:0]    term;
    logic [63:0]    e;
    longint         sum;
    int unsigned    i;
    longint unsigned j;
    a     = udiv64((64'(k) * 64'd8) << 32, 64'(TanhSegments));
    whole = a >> 32;
    frac  = a & 64'hFFFF_FFFF;
    term  = OneQ32;
    sum   = longint'(OneQ32);
    for (i = 1; i <= 24; i++) begin
      term = udiv64((term * frac) >> 32, 64'(i));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum > 0) ? 64'(sum) : 64'd0;
    if (e > OneQ32) begin
      e = OneQ32;
    end
    for (j = 0; j < whole; j++) begin
      e = (e * ExpM1Q32 + 64'h8000_0000) >> 32;
    end
    return e;
  endfunction

  function automatic shape_tab_t build_shape_table();
    shape_tab_t  t;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    int unsigned k;
    for (k = 0; k <= TanhSegments; k++) begin
      e    = exp_neg_q32(k);
      num  = OneQ32 - e;
      den  = OneQ32 + e;
      t[k] = SampleW'(udiv64(num * 64'd65536 + den, 64'd2 * den));
    end
    return t;
  endfunction

  localparam shape_tab_t ShapeTable = build_shape_table();

endpackage

@@ hw/rtl/tsd_if.sv @@
// Stream interfaces for the input and output sample words.
interface tsd_in_if;
  import tsd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface tsd_out_if;
  import tsd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

@@ hw/rtl/tanh_soft_clip_distortion_core.sv @@
// Each accepted input word runs through the shaper and mixer pipelines to its output word.
// Throughput: one word per cycle; every stage holds its own valid bit, so
// bubbles close up and a stalled output blocks input only once all stages are full.
// Reset: asynchronous, active low; clears all valid bits and sets the gains to 1.0
// and the mix to fully wet. Write configuration only while no word is in flight.
module tanh_soft_clip_distortion_core
  import tsd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  tsd_in_if.sink       in_i,
  tsd_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [GainW-1:0] cfg_data_i
);

  // Configuration registers
  logic [GainW-1:0] drive_gain_q;
  logic [MixW-1:0]  wet_mix_q;
  logic [GainW-1:0] post_gain_q;
  logic [MixW-1:0]  mix_clamped;

  // Shaper to mixer word
  logic    shaped_valid;
  logic    shaped_ready;
  shaped_t shaped_data;

  // Write the addressed register; drop writes to unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= GainW'(4096);
      wet_mix_q    <= MixW'(MixOne);
      post_gain_q  <= GainW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DRIVE_GAIN: drive_gain_q <= cfg_data_i;
        CFG_WET_MIX:    wet_mix_q    <= cfg_data_i[MixW-1:0];
        CFG_POST_GAIN:  post_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Mix settings above one act as fully wet.
  assign mix_clamped = (wet_mix_q > MixW'(MixOne)) ? MixW'(MixOne) : wet_mix_q;

  // Stages 1-3: drive multiply, breakpoint lookup, interpolation.
  tsd_shaper u_shaper (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .drive_gain_i (drive_gain_q),
    .out_valid_o  (shaped_valid),
    .out_ready_i  (shaped_ready),
    .out_data_o   (shaped_data)
  );

  // Stages 4-7: blend products, blend sum, output gain, round and saturate.
  tsd_mixer u_mixer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (shaped_valid),
    .in_ready_o  (shaped_ready),
    .in_data_i   (shaped_data),
    .mix_i       (mix_clamped),
    .post_gain_i (post_gain_q),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // Input may stall only when the output holds a word that is not taken.
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  // No word may leave in the first cycle after reset.
  a_empty_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_o.valid)
    else $error("output valid right after reset");

  // A ready output enables every stage, so the input is ready in the same cycle.
  a_drain_frees_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input not ready while output ready");
`endif

endmodule

@@ hw/rtl/tsd_shaper.sv @@
// Drive gain and piecewise-linear tanh shaper, three pipeline stages.
module tsd_shaper
  import tsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  tsd_in_if.sink           in_i,
  input  logic [GainW-1:0] drive_gain_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output shaped_t          out_data_o
);

  // stage enables, back to front
  logic en1, en2, en3;

  // stage 1: magnitude times drive
  logic                      vld1_q;
  logic signed [SampleW-1:0] x1_q;
  logic                      neg1_q;
  logic [MagW-1:0]           mag1_q;
  logic [SampleW-1:0]        ax;
  logic [MagW-1:0]           mag_d;

  // stage 2: table lookup
  logic                      vld2_q;
  logic signed [SampleW-1:0] x2_q;
  logic                      neg2_q;
  logic                      sat2_q;
  logic [SampleW-1:0]        lo2_q;
  logic [SampleW-1:0]        diff2_q;
  logic [FracW-1:0]          fr2_q;
  logic [SegW:0]             idx;
  logic [SampleW-1:0]        lo_d;
  logic [SampleW-1:0]        hi_d;

  // stage 3: interpolation and sign
  logic                      vld3_q;
  shaped_t                   out3_q;
  logic [SampleW+FracW-1:0]  prod;
  logic [SampleW-1:0]        y;

  assign en3 = !vld3_q || out_ready_i;
  assign en2 = !vld2_q || en3;
  assign en1 = !vld1_q || en2;
  assign in_i.ready = en1;

  assign ax    = in_i.in_sample[SampleW-1] ? SampleW'(-in_i.in_sample)
                                           : SampleW'(in_i.in_sample);
  assign mag_d = MagW'(ax) * MagW'(drive_gain_i);

  assign idx  = {1'b0, mag1_q[FourBit-1 -: SegW]};
  assign lo_d = ShapeTable[idx];
  assign hi_d = ShapeTable[idx + 1'b1];

  assign prod = (SampleW + FracW)'(diff2_q) * (SampleW + FracW)'(fr2_q);
  assign y    = sat2_q ? SampleW'(1 << (SampleW - 1))
                       : lo2_q + SampleW'((prod + (1 << (FracW - 1))) >> FracW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= in_i.valid;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q   <= in_i.in_sample;
      neg1_q <= in_i.in_sample[SampleW-1];
      mag1_q <= mag_d;
    end
    if (en2) begin
      x2_q    <= x1_q;
      neg2_q  <= neg1_q;
      sat2_q  <= |mag1_q[MagW-1:FourBit];
      lo2_q   <= lo_d;
      diff2_q <= (hi_d > lo_d) ? hi_d - lo_d : '0;
      fr2_q   <= mag1_q[FracW-1:0];
    end
    if (en3) begin
      out3_q.x <= x2_q;
      out3_q.w <= neg2_q ? -$signed({1'b0, y}) : $signed({1'b0, y});
    end
  end

  assign out_valid_o = vld3_q;
  assign out_data_o  = out3_q;

endmodule

@@ hw/rtl/tsd_mixer.sv @@
// Dry/wet blend, output gain, rounding and saturation, four pipeline stages.
module tsd_mixer
  import tsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  shaped_t          in_data_i,
  input  logic [MixW-1:0]  mix_i,
  input  logic [GainW-1:0] post_gain_i,
  tsd_out_if.source        out_o
);

  localparam int unsigned DryW = SampleW + MixW + 1;
  localparam int unsigned WetW = ShapedW + MixW + 1;
  localparam int unsigned RndW = ScaledW + 1;
  localparam int unsigned ResW = RndW - RoundShift;

  logic en4, en5, en6, en7;

  logic                      vld4_q, vld5_q, vld6_q, vld7_q;
  logic signed [DryW-1:0]    dry4_q;
  logic signed [WetW-1:0]    wet4_q;
  logic signed [BlendW-1:0]  b5_q;
  logic signed [ScaledW-1:0] v6_q;
  logic signed [SampleW-1:0] out7_q;

  logic [MixW-1:0]           dry_mix;
  logic signed [DryW-1:0]    dry_d;
  logic signed [WetW-1:0]    wet_d;
  logic signed [BlendW-1:0]  b_d;
  logic signed [ScaledW-1:0] v_d;
  logic signed [RndW-1:0]    rnd;
  logic signed [ResW-1:0]    res;
  logic signed [SampleW-1:0] sat_d;

  assign en7 = !vld7_q || out_o.ready;
  assign en6 = !vld6_q || en7;
  assign en5 = !vld5_q || en6;
  assign en4 = !vld4_q || en5;
  assign in_ready_o = en4;

  assign dry_mix = MixW'(MixOne) - mix_i;
  assign dry_d   = $signed({1'b0, dry_mix}) * in_data_i.x;
  assign wet_d   = $signed({1'b0, mix_i}) * in_data_i.w;
  assign b_d     = BlendW'(dry4_q) + BlendW'(wet4_q);
  assign v_d     = ScaledW'(b5_q) * ScaledW'($signed({1'b0, post_gain_i}));

  // round half up, then clamp to the sample range
  assign rnd = RndW'(v6_q) + RndW'(1 << (RoundShift - 1));
  assign res = ResW'(rnd >>> RoundShift);

  always_comb begin
    if (res > ResW'(32767)) begin
      sat_d = 16'sh7FFF;
    end else if (res < -ResW'(32768)) begin
      sat_d = -16'sh8000;
    end else begin
      sat_d = SampleW'(res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else begin
      if (en4) vld4_q <= in_valid_i;
      if (en5) vld5_q <= vld4_q;
      if (en6) vld6_q <= vld5_q;
      if (en7) vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      dry4_q <= dry_d;
      wet4_q <= wet_d;
    end
    if (en5) b5_q   <= b_d;
    if (en6) v6_q   <= v_d;
    if (en7) out7_q <= sat_d;
  end

  assign out_o.valid      = vld7_q;
  assign out_o.out_sample = out7_q;

endmodule
